@@ hdl/lstc_pkg.sv @@
// Shared constants, types and helper functions of the leg stance trim controller.
package lstc_pkg;

    // Geometry
    localparam int LEG_COUNT = 4;
    localparam int DATA_W    = 16;
    localparam int SMOOTH_W  = 24;
    localparam int SLEW_W    = 12;
    localparam int GAIN_W    = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Stance count and divisor widths (divisor reaches LEG_COUNT + 2)
    localparam int NW  = $clog2(LEG_COUNT + 1);
    localparam int DVW = $clog2(LEG_COUNT + 3);

    // Quotient width of the shared divider
    localparam int QW = 20;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CMD_ALPHA  = 2'd0,
        REG_SLEW_LIMIT = 2'd1,
        REG_THIGH_GAIN = 2'd2,
        REG_CALF_FF    = 2'd3
    } cfg_reg_t;

    // Register reset values
    localparam logic [CFG_W-1:0]  CMD_ALPHA_RST  = 16'd5243;
    localparam logic [SLEW_W-1:0] SLEW_LIMIT_RST = 12'd61;
    localparam logic [GAIN_W-1:0] THIGH_GAIN_RST = 15'd3686;
    localparam logic [GAIN_W-1:0] CALF_FF_RST    = 15'd4822;

    // Divider request and response
    typedef struct packed {
        logic           start;
        logic [QW-1:0]  dividend;
        logic [DVW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [QW-1:0] quotient;
    } div_rsp_t;

    // Control shared by all lanes
    typedef struct packed {
        logic              update;
        logic [SLEW_W-1:0] slew;
        logic [DATA_W-1:0] thigh_tgt;
        logic [DATA_W-1:0] calf_tgt;
    } lane_ctl_t;

    // Saturate a signed 24-bit value to signed 16 bits
    function automatic logic [DATA_W-1:0] sat16(input logic [23:0] v);
        if ($signed(v) > 24'sd32767)
        begin
            return 16'h7FFF;
        end
        else if ($signed(v) < -24'sd32768)
        begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Move a trim toward its target by at most slew
    function automatic logic [DATA_W-1:0] trim_step(
        input logic [DATA_W-1:0] tgt,
        input logic [DATA_W-1:0] trim,
        input logic [SLEW_W-1:0] slew
    );
        logic signed [16:0] d;
        logic signed [16:0] lim;
        d   = $signed({tgt[15], tgt}) - $signed({trim[15], trim});
        lim = $signed({5'b0, slew});
        if (d > lim)
        begin
            d = lim;
        end
        else if (d < -lim)
        begin
            d = -lim;
        end
        return trim + d[15:0];
    endfunction

endpackage

@@ hdl/lstc_if.sv @@
// Handshake channels: sensor/plan word in, joint command word out.
interface lstc_tick_if;
    import lstc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    cmd_vx;
    logic [DATA_W-1:0]    meas_vx;
    logic [LEG_COUNT-1:0] contact_mask;
    logic                 run_enable;
    logic [DATA_W-1:0]    nominal_thigh_0;
    logic [DATA_W-1:0]    nominal_thigh_1;
    logic [DATA_W-1:0]    nominal_thigh_2;
    logic [DATA_W-1:0]    nominal_thigh_3;
    logic [DATA_W-1:0]    nominal_calf_0;
    logic [DATA_W-1:0]    nominal_calf_1;
    logic [DATA_W-1:0]    nominal_calf_2;
    logic [DATA_W-1:0]    nominal_calf_3;

    modport source (
        output valid, cmd_vx, meas_vx, contact_mask, run_enable,
               nominal_thigh_0, nominal_thigh_1, nominal_thigh_2, nominal_thigh_3,
               nominal_calf_0, nominal_calf_1, nominal_calf_2, nominal_calf_3,
        input  ready
    );

    modport sink (
        input  valid, cmd_vx, meas_vx, contact_mask, run_enable,
               nominal_thigh_0, nominal_thigh_1, nominal_thigh_2, nominal_thigh_3,
               nominal_calf_0, nominal_calf_1, nominal_calf_2, nominal_calf_3,
        output ready
    );
endinterface

interface lstc_joint_if;
    import lstc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] thigh_pos_0;
    logic [DATA_W-1:0] thigh_pos_1;
    logic [DATA_W-1:0] thigh_pos_2;
    logic [DATA_W-1:0] thigh_pos_3;
    logic [DATA_W-1:0] calf_pos_0;
    logic [DATA_W-1:0] calf_pos_1;
    logic [DATA_W-1:0] calf_pos_2;
    logic [DATA_W-1:0] calf_pos_3;

    modport source (
        output valid, thigh_pos_0, thigh_pos_1, thigh_pos_2, thigh_pos_3,
               calf_pos_0, calf_pos_1, calf_pos_2, calf_pos_3,
        input  ready
    );

    modport sink (
        input  valid, thigh_pos_0, thigh_pos_1, thigh_pos_2, thigh_pos_3,
               calf_pos_0, calf_pos_1, calf_pos_2, calf_pos_3,
        output ready
    );
endinterface

@@ hdl/lstc_div.sv @@
// Shared restoring divider, one quotient bit per cycle, small divisor.
module lstc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lstc_pkg::div_req_t req,
    output lstc_pkg::div_rsp_t rsp
);
    import lstc_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [QW-1:0]  quo_reg, quo_next;
    logic [DVW-1:0] dvs_reg, dvs_next;

    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           ge;

    // One restoring step
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVW-1:0] : trial[DVW-1:0];
            quo_next = {quo_reg[QW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ hdl/lstc_lane.sv @@
// One leg lane: holds the thigh and calf trims and forms the joint commands.
module lstc_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lstc_pkg::lane_ctl_t            ctl,
    input  logic                           stance,
    input  logic [lstc_pkg::DATA_W-1:0]    nom_thigh,
    input  logic [lstc_pkg::DATA_W-1:0]    nom_calf,
    output logic [lstc_pkg::DATA_W-1:0]    thigh_pos,
    output logic [lstc_pkg::DATA_W-1:0]    calf_pos
);
    import lstc_pkg::*;

    logic [DATA_W-1:0] thigh_trim_reg, thigh_trim_next;
    logic [DATA_W-1:0] calf_trim_reg, calf_trim_next;

    // On an update, slew-limited step for stance and clear for swing; otherwise hold
    always_comb
    begin
        thigh_trim_next = thigh_trim_reg;
        calf_trim_next  = calf_trim_reg;
        if (ctl.update)
        begin
            if (stance)
            begin
                thigh_trim_next = trim_step(ctl.thigh_tgt, thigh_trim_reg, ctl.slew);
                calf_trim_next  = trim_step(ctl.calf_tgt, calf_trim_reg, ctl.slew);
            end
            else
            begin
                thigh_trim_next = '0;
                calf_trim_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thigh_trim_reg <= '0;
            calf_trim_reg  <= '0;
        end
        else
        begin
            thigh_trim_reg <= thigh_trim_next;
            calf_trim_reg  <= calf_trim_next;
        end
    end

    // Nominal plus trim, saturated
    assign thigh_pos = sat16({{8{nom_thigh[15]}}, nom_thigh}
                             + {{8{thigh_trim_reg[15]}}, thigh_trim_reg});
    assign calf_pos  = sat16({{8{nom_calf[15]}}, nom_calf}
                             + {{8{calf_trim_reg[15]}}, calf_trim_reg});

endmodule

@@ hdl/leg_stance_trim_controller.sv @@
// Top level: command filter, target solve, leg lanes and output merge.
//
// Usage:
//   tick   : input word per control tick (speeds, contact mask, run flag,
//            nominal joint angles). Taken when valid and ready are high.
//   joints : output word with thigh and calf commands for every leg.
//   cfg_*  : register writes, taken on any clock edge with cfg_we high;
//            write only while the block is idle.
// A word with run_enable low is taken and gives no output.
// Otherwise the word runs through the filter, target and division steps, and
// the next word is taken only once its result has left the last step. Each
// word uses the shared 20-step divider twice, once for the thigh target and
// once for the calf target.
// A finished word waits in the output register while the receiver stalls;
// a new word is taken meanwhile and its result waits at the last step until
// the register frees up.
// Reset clears the command filter, all trims and the output valid, and loads
// the register defaults.
module leg_stance_trim_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    lstc_tick_if.sink                         tick,
    lstc_joint_if.source                      joints,
    input  logic                              cfg_we,
    input  logic [lstc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lstc_pkg::CFG_W-1:0]        cfg_data
);
    import lstc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILT_MUL,
        S_FILT_ADD,
        S_ERR,
        S_GAIN_MUL,
        S_ABS,
        S_DIVT_GO,
        S_DIVT_WAIT,
        S_DIVC_GO,
        S_DIVC_WAIT,
        S_TRIM,
        S_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [CFG_W-1:0]  alpha_reg;
    logic [SLEW_W-1:0] slew_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] ff_reg;

    // Filter and target datapath
    logic [SMOOTH_W-1:0] smooth_reg;
    logic [24:0]         diff_reg;
    logic [41:0]         prod_reg;
    logic [DATA_W-1:0]   meas_reg;
    logic [24:0]         err_reg;
    logic [40:0]         num_reg;
    logic [39:0]         mag_reg;
    logic                neg_reg;
    logic [NW-1:0]       n_reg;
    logic [LEG_COUNT-1:0] mask_reg;
    logic [DATA_W-1:0]   thigh_tgt_reg;
    logic [DATA_W-1:0]   calf_tgt_reg;
    logic [DATA_W-1:0]   nom_thigh_reg [LEG_COUNT];
    logic [DATA_W-1:0]   nom_calf_reg  [LEG_COUNT];

    // Output register
    logic                out_valid_reg;
    logic [DATA_W-1:0]   thigh_out_reg [LEG_COUNT];
    logic [DATA_W-1:0]   calf_out_reg  [LEG_COUNT];

    logic                take;
    logic                out_free;
    logic                out_load;
    logic [41:0]         rnd;
    logic [DVW-1:0]      dvs_thigh;
    logic [DVW-1:0]      dvs_calf;
    logic [40:0]         thigh_sum;
    logic [QW-1:0]       q;

    div_req_t            div_req;
    div_rsp_t            div_rsp;
    lane_ctl_t           lane_ctl;
    logic [DATA_W-1:0]   thigh_pos_w [LEG_COUNT];
    logic [DATA_W-1:0]   calf_pos_w  [LEG_COUNT];

    assign tick.ready = (state_reg == S_IDLE);
    assign take       = tick.valid && tick.ready;
    assign out_free   = !out_valid_reg || joints.ready;
    assign out_load   = (state_reg == S_OUT) && out_free;

    // Filter rounding: (alpha * diff + 2^15) >> 16
    assign rnd = prod_reg + 42'd32768;

    // Divisors: 2 + n for thigh, max(n,1) for calf
    assign dvs_thigh = DVW'(n_reg) + DVW'(2);
    assign dvs_calf  = (n_reg == '0) ? DVW'(1) : DVW'(n_reg);
    assign thigh_sum = {1'b0, mag_reg} + (41'(dvs_thigh) << 19);
    assign q         = div_rsp.quotient;

    // Divider requests
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = thigh_sum[39:20];
        div_req.divisor  = dvs_thigh;
        case (state_reg)
            S_DIVT_GO:
            begin
                div_req.start = 1'b1;
            end
            S_DIVC_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = QW'(ff_reg) + QW'(dvs_calf >> 1);
                div_req.divisor  = dvs_calf;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    lstc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Lanes
    assign lane_ctl.update    = (state_reg == S_TRIM);
    assign lane_ctl.slew      = slew_reg;
    assign lane_ctl.thigh_tgt = thigh_tgt_reg;
    assign lane_ctl.calf_tgt  = calf_tgt_reg;

    for (genvar i = 0; i < LEG_COUNT; i++)
    begin : g_lane
        lstc_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (lane_ctl),
            .stance    (mask_reg[i]),
            .nom_thigh (nom_thigh_reg[i]),
            .nom_calf  (nom_calf_reg[i]),
            .thigh_pos (thigh_pos_w[i]),
            .calf_pos  (calf_pos_w[i])
        );
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= CMD_ALPHA_RST;
            slew_reg  <= SLEW_LIMIT_RST;
            gain_reg  <= THIGH_GAIN_RST;
            ff_reg    <= CALF_FF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CMD_ALPHA:  alpha_reg <= cfg_data;
                REG_SLEW_LIMIT: slew_reg  <= cfg_data[SLEW_W-1:0];
                REG_THIGH_GAIN: gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_CALF_FF:    ff_reg    <= cfg_data[GAIN_W-1:0];
                default:        alpha_reg <= alpha_reg;
            endcase
        end
    end

    // Sequencer, filter state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // load a finished word, or drop the one just taken
            out_valid_reg <= out_load || (out_valid_reg && !joints.ready);
            case (state_reg)
                S_IDLE:
                begin
                    if (take && tick.run_enable)
                    begin
                        state_reg <= S_FILT_MUL;
                    end
                end
                S_FILT_MUL:  state_reg <= S_FILT_ADD;
                S_FILT_ADD:
                begin
                    smooth_reg <= smooth_reg + rnd[39:16];
                    state_reg  <= S_ERR;
                end
                S_ERR:       state_reg <= S_GAIN_MUL;
                S_GAIN_MUL:  state_reg <= S_ABS;
                S_ABS:       state_reg <= S_DIVT_GO;
                S_DIVT_GO:   state_reg <= S_DIVT_WAIT;
                S_DIVT_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_DIVC_GO;
                    end
                end
                S_DIVC_GO:   state_reg <= S_DIVC_WAIT;
                S_DIVC_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_TRIM;
                    end
                end
                S_TRIM:      state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            diff_reg  <= {tick.cmd_vx[15], tick.cmd_vx, 8'b0}
                         - {smooth_reg[SMOOTH_W-1], smooth_reg};
            meas_reg  <= tick.meas_vx;
            mask_reg  <= tick.contact_mask;
            n_reg     <= NW'($countones(tick.contact_mask));
            nom_thigh_reg[0] <= tick.nominal_thigh_0;
            nom_thigh_reg[1] <= tick.nominal_thigh_1;
            nom_thigh_reg[2] <= tick.nominal_thigh_2;
            nom_thigh_reg[3] <= tick.nominal_thigh_3;
            nom_calf_reg[0]  <= tick.nominal_calf_0;
            nom_calf_reg[1]  <= tick.nominal_calf_1;
            nom_calf_reg[2]  <= tick.nominal_calf_2;
            nom_calf_reg[3]  <= tick.nominal_calf_3;
        end
        if (state_reg == S_FILT_MUL)
        begin
            prod_reg <= 42'($signed({1'b0, alpha_reg}) * $signed(diff_reg));
        end
        if (state_reg == S_ERR)
        begin
            err_reg <= {meas_reg[15], meas_reg, 8'b0}
                       - {smooth_reg[SMOOTH_W-1], smooth_reg};
        end
        if (state_reg == S_GAIN_MUL)
        begin
            num_reg <= 41'($signed({1'b0, gain_reg}) * $signed(err_reg));
        end
        if (state_reg == S_ABS)
        begin
            neg_reg <= num_reg[40];
            mag_reg <= num_reg[40] ? 40'(-num_reg) : num_reg[39:0];
        end
        // Thigh target: signed quotient, saturated
        if (state_reg == S_DIVT_WAIT && div_rsp.done)
        begin
            if (!neg_reg && q > QW'(32767))
            begin
                thigh_tgt_reg <= 16'h7FFF;
            end
            else if (neg_reg && q > QW'(32768))
            begin
                thigh_tgt_reg <= 16'h8000;
            end
            else
            begin
                thigh_tgt_reg <= neg_reg ? 16'(-q[15:0]) : q[15:0];
            end
        end
        // Calf target: negative weight share
        if (state_reg == S_DIVC_WAIT && div_rsp.done)
        begin
            calf_tgt_reg <= 16'(16'd0 - q[15:0]);
        end
        // Merge lane results into the output word
        if (out_load)
        begin
            for (int i = 0; i < LEG_COUNT; i++)
            begin
                thigh_out_reg[i] <= thigh_pos_w[i];
                calf_out_reg[i]  <= calf_pos_w[i];
            end
        end
    end

    assign joints.valid       = out_valid_reg;
    assign joints.thigh_pos_0 = thigh_out_reg[0];
    assign joints.thigh_pos_1 = thigh_out_reg[1];
    assign joints.thigh_pos_2 = thigh_out_reg[2];
    assign joints.thigh_pos_3 = thigh_out_reg[3];
    assign joints.calf_pos_0  = calf_out_reg[0];
    assign joints.calf_pos_1  = calf_out_reg[1];
    assign joints.calf_pos_2  = calf_out_reg[2];
    assign joints.calf_pos_3  = calf_out_reg[3];

`ifndef NO_ASSERTIONS
    // A new output word only comes from the output step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("output word appeared outside the output step");

    // Divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIVT_WAIT || state_reg == S_DIVC_WAIT))
        else $error("divider finished outside a division step");

    // Stance count matches the latched contact mask during the solve
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> ($countones(mask_reg) == int'(n_reg)))
        else $error("stance count disagrees with contact mask");

    // The divider is never started while busy
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
`endif

endmodule
